// ----- rtl/pnps_pkg.sv -----
// Shared constants for the path nearest point search block.
// No dependencies; used by pnps_dist and path_nearest_point_search.
`timescale 1ns / 1ps

package pnps_pkg;

    localparam int PATH_DEPTH_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int FUNC_W  = 2;
    localparam int STOP_W  = 40;
    localparam int INDEX_W = 10;
    localparam int DIST_W  = 49;

    localparam logic [STOP_W-1:0] STOP_RESET = 40'd262144;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

endpackage

// ----- rtl/pnps_dist.sv -----
// Pipelined squared distance unit: one point pair per cycle, three stages.
// Saturates at the all-ones DIST_W value. Depends on pnps_pkg.
`timescale 1ns / 1ps

module pnps_dist #(
    parameter int COORD_WIDTH = pnps_pkg::COORD_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [COORD_WIDTH-1:0]       ax,
    input  logic [COORD_WIDTH-1:0]       ay,
    input  logic [COORD_WIDTH-1:0]       bx,
    input  logic [COORD_WIDTH-1:0]       by,
    output logic                         out_valid,
    output logic [pnps_pkg::DIST_W-1:0]  dist_sq
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int SAT_W  = (SUM_W > pnps_pkg::DIST_W) ? SUM_W : pnps_pkg::DIST_W;

    logic [DIFF_W-1:0] dx_raw, dy_raw, dx_abs, dy_abs;
    logic [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg;
    logic [SUM_W-1:0]  sum;
    logic [SAT_W-1:0]  sum_ext;
    logic [pnps_pkg::DIST_W-1:0] sat;
    logic [pnps_pkg::DIST_W-1:0] dist_reg;
    logic              va_reg, vb_reg, vc_reg;

    assign dx_raw = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
    assign dy_raw = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
    assign dx_abs = dx_raw[DIFF_W-1] ? (~dx_raw + DIFF_W'(1)) : dx_raw;
    assign dy_abs = dy_raw[DIFF_W-1] ? (~dy_raw + DIFF_W'(1)) : dy_raw;

    assign sum     = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign sum_ext = SAT_W'(sum);
    assign sat     = (sum_ext > SAT_W'(pnps_pkg::DIST_MAX)) ? pnps_pkg::DIST_MAX
                                                            : sum_ext[pnps_pkg::DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
        dx_reg   <= dx_abs;
        dy_reg   <= dy_abs;
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
        dist_reg <= sat;
    end

    assign out_valid = vc_reg;
    assign dist_sq   = dist_reg;

endmodule

// ----- rtl/path_nearest_point_search.sv -----
// Path nearest point search: path store, scan sequencer and result register.
// Depends on pnps_pkg and pnps_dist.
//
// Usage: items arrive on the s_ channel (s_func, s_x_coord, s_y_coord).
// Clear and append give no result; an append to a full path is dropped.
// A query gives one result on the m_ channel. With no path held the query
// goes straight to the result, with path_valid low. Otherwise the last point
// is checked against stop_radius_sq; if inside, the path is emptied and
// goal_reached is set. Otherwise every held point is read through the scan
// read port of the path memory, one per cycle, into the three-stage
// distance unit. s_ready is low while a query is in progress.
// The finished result sits in an output register; while the receiver
// stalls, new items are still accepted and only the next result waits.
// cfg_data writes stop_radius_sq whenever cfg_valid is high (cfg_ready is
// always high); write it only while the block is idle.
// Reset empties the path, drops any pending result and restores the stop
// radius to 262144. No clearing pass is needed.
`timescale 1ns / 1ps

module path_nearest_point_search #(
    parameter int PATH_DEPTH  = pnps_pkg::PATH_DEPTH_DEF,
    parameter int COORD_WIDTH = pnps_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pnps_pkg::STOP_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pnps_pkg::FUNC_W-1:0]   s_func,
    input  logic signed [COORD_WIDTH-1:0] s_x_coord,
    input  logic signed [COORD_WIDTH-1:0] s_y_coord,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_path_valid,
    output logic                          m_goal_reached,
    output logic [pnps_pkg::INDEX_W-1:0]  m_nearest_index,
    output logic [pnps_pkg::DIST_W-1:0]   m_nearest_dist_sq
);

    localparam int IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);
    localparam int PT_W  = 2 * COORD_WIDTH;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PATH_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_RESULT} state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              iss_reg, iss_next;
    logic [CNT_W-1:0]              rcv_reg, rcv_next;
    logic [COORD_WIDTH-1:0]        px_reg, px_next, py_reg, py_next;
    logic [pnps_pkg::DIST_W-1:0]   best_d_reg, best_d_next;
    logic [IDX_W-1:0]              best_i_reg, best_i_next;
    logic                          pv_reg, pv_next, goal_reg, goal_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_pv_reg, m_pv_next, m_goal_reg, m_goal_next;
    logic [pnps_pkg::INDEX_W-1:0]  m_idx_reg, m_idx_next;
    logic [pnps_pkg::DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic [pnps_pkg::STOP_W-1:0]   stop_reg;

    logic [PT_W-1:0]               mem [PATH_DEPTH];
    logic [PT_W-1:0]               rd_data_reg;
    logic                          rd_vld_reg;
    logic                          rd_en, wr_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [CNT_W-1:0]              last_cnt;
    logic [IDX_W+pnps_pkg::INDEX_W-1:0] idx_wide;

    logic                          d_vld;
    logic [pnps_pkg::DIST_W-1:0]   d_val;
    logic                          in_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign wr_en     = in_xfer && (s_func == pnps_pkg::FUNC_APPEND) && (count_reg < DEPTH_C);
    assign last_cnt  = count_reg - CNT_W'(1);
    assign idx_wide  = {{pnps_pkg::INDEX_W{1'b0}}, best_i_reg};

    pnps_dist #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .ax        (px_reg),
        .ay        (py_reg),
        .bx        (rd_data_reg[PT_W-1:COORD_WIDTH]),
        .by        (rd_data_reg[COORD_WIDTH-1:0]),
        .out_valid (d_vld),
        .dist_sq   (d_val)
    );

    // Path memory: append port and scan read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= {s_x_coord, s_y_coord};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg <= pnps_pkg::STOP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            stop_reg <= cfg_data;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        rcv_next     = rcv_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        best_d_next  = best_d_reg;
        best_i_next  = best_i_reg;
        pv_next      = pv_reg;
        goal_next    = goal_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pv_next    = m_pv_reg;
        m_goal_next  = m_goal_reg;
        m_idx_next   = m_idx_reg;
        m_dist_next  = m_dist_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        pnps_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        pnps_pkg::FUNC_APPEND: begin
                            if (count_reg < DEPTH_C) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        pnps_pkg::FUNC_QUERY: begin
                            px_next     = s_x_coord;
                            py_next     = s_y_coord;
                            best_d_next = '0;
                            best_i_next = '0;
                            goal_next   = 1'b0;
                            iss_next    = '0;
                            if (count_reg == '0) begin
                                pv_next    = 1'b0;
                                state_next = ST_RESULT;
                            end else begin
                                state_next = ST_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (iss_reg == '0) begin
                    rd_en    = 1'b1;
                    rd_addr  = last_cnt[IDX_W-1:0];
                    iss_next = CNT_W'(1);
                end
                if (d_vld) begin
                    if (d_val < pnps_pkg::DIST_W'(stop_reg)) begin
                        count_next = '0;
                        pv_next    = 1'b1;
                        goal_next  = 1'b1;
                        state_next = ST_RESULT;
                    end else begin
                        iss_next   = '0;
                        rcv_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (iss_reg < count_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[IDX_W-1:0];
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (d_vld) begin
                    // first of equal minima wins
                    if ((rcv_reg == '0) || (d_val < best_d_reg)) begin
                        best_d_next = d_val;
                        best_i_next = rcv_reg[IDX_W-1:0];
                    end
                    rcv_next = rcv_reg + CNT_W'(1);
                    if (rcv_reg == last_cnt) begin
                        pv_next    = 1'b1;
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pv_next    = pv_reg;
                    m_goal_next  = goal_reg;
                    m_idx_next   = idx_wide[pnps_pkg::INDEX_W-1:0];
                    m_dist_next  = best_d_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            iss_reg     <= '0;
            rcv_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            rcv_reg     <= rcv_next;
            m_valid_reg <= m_valid_next;
        end
        px_reg     <= px_next;
        py_reg     <= py_next;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        pv_reg     <= pv_next;
        goal_reg   <= goal_next;
        m_pv_reg   <= m_pv_next;
        m_goal_reg <= m_goal_next;
        m_idx_reg  <= m_idx_next;
        m_dist_reg <= m_dist_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_path_valid      = m_pv_reg;
    assign m_goal_reached    = m_goal_reg;
    assign m_nearest_index   = m_idx_reg;
    assign m_nearest_dist_sq = m_dist_reg;

endmodule
